// ===== rtl/assert_macros.svh =====
// shared assertion macros for the cache checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define LKVC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lkvc assertion failed");

// next-cycle implication, disabled while reset is active
`define LKVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lkvc assertion failed");

`endif

// ===== rtl/lkvc_pkg.sv =====
package lkvc_pkg;

    // table geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int AGE_W   = $clog2(ENTRIES);
    localparam int OCC_W   = $clog2(ENTRIES + 1);

    // capacity register
    localparam int CAP_W = 5;
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // value reported by a get that misses
    localparam logic signed [31:0] MISS_VALUE = -32'sd1;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_op;

    typedef struct packed {
        t_op                operation;
        logic signed [31:0] key;
        logic signed [31:0] put_value;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
    } t_rsp;

endpackage

// ===== rtl/lru_key_value_cache_top.sv =====
// fully associative key-value cache with true lru replacement
// path: request into the input register, its result into the result register driving o_rsp
// one request per cycle unless stalled; all keys compared and all ages updated in one pass
// reset: valid marks, occupancy and both pipeline stages cleared, capacity set to 16
// no clearing pass: the valid marks are flip-flops cleared in the reset cycle
module lru_key_value_cache_top import lkvc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CAP_W-1:0] i_cfg_wr_data,
    input  logic             i_req_valid,
    output logic             o_req_stall,
    input  t_req             i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_stall,
    output t_rsp             o_rsp
);

    // pipeline registers
    logic             r_req_valid;
    t_req             r_req;
    logic             r_rsp_valid;
    t_rsp             r_rsp;
    logic [CAP_W-1:0] r_cap;

    // table state
    logic                      r_valid [ENTRIES];
    logic signed [31:0]        r_key   [ENTRIES];
    logic signed [31:0]        r_value [ENTRIES];
    logic [AGE_W-1:0]          r_age   [ENTRIES];
    logic [OCC_W-1:0]          r_occ;

    logic                      n_valid [ENTRIES];
    logic signed [31:0]        n_key   [ENTRIES];
    logic signed [31:0]        n_value [ENTRIES];
    logic [AGE_W-1:0]          n_age   [ENTRIES];
    logic [OCC_W-1:0]          n_occ;
    t_rsp                      n_rsp;

    logic             can_adv;
    logic             fire;
    logic             found_any;
    logic [IDX_W-1:0] found_idx;
    logic             free_any;
    logic [IDX_W-1:0] free_idx;
    logic             old_any;
    logic [IDX_W-1:0] old_idx;
    logic [AGE_W-1:0] old_age;
    logic [CMP_W-1:0] eff_cap;
    logic             room;
    logic             use_free;
    logic [IDX_W-1:0] slot;
    logic             evict;

    // handshake
    assign can_adv     = !r_rsp_valid || !i_rsp_stall;
    assign fire        = r_req_valid && can_adv;
    assign o_req_stall = r_req_valid && !can_adv;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (i_req_valid && !o_req_stall) begin
            r_req_valid <= 1'b1;
        end else if (can_adv) begin
            r_req_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && !o_req_stall) begin
            r_req <= i_req;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (fire) begin
            r_rsp_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rsp <= n_rsp;
        end
    end

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_cap <= i_cfg_wr_data;
        end
    end

    // effective capacity: zero counts as one, saturate at table size
    always_comb begin
        eff_cap = CMP_W'(r_cap);
        if (eff_cap == '0) begin
            eff_cap = CMP_W'(1);
        end else if (eff_cap > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end
    end

    assign room    = CMP_W'(r_occ) < eff_cap;
    // ages of valid entries are a permutation of 0..occ-1, so the oldest has age occ-1
    assign old_age = AGE_W'(r_occ - OCC_W'(1));

    // key match, free slot and oldest entry, lowest index first
    always_comb begin
        found_any = 1'b0;
        found_idx = '0;
        free_any  = 1'b0;
        free_idx  = '0;
        old_any   = 1'b0;
        old_idx   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!found_any && r_valid[i] && (r_key[i] == r_req.key)) begin
                found_any = 1'b1;
                found_idx = IDX_W'(i);
            end
            if (!free_any && !r_valid[i]) begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
            if (!old_any && r_valid[i] && (r_age[i] == old_age)) begin
                old_any = 1'b1;
                old_idx = IDX_W'(i);
            end
        end
    end

    // victim choice for a put miss
    always_comb begin
        use_free = room && free_any;
        if (use_free) begin
            slot = free_idx;
        end else if (old_any) begin
            slot = old_idx;
        end else begin
            slot = '0;
        end
        evict = !use_free && r_valid[slot];
    end

    // next table state and response
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            n_valid[i] = r_valid[i];
            n_key[i]   = r_key[i];
            n_value[i] = r_value[i];
            n_age[i]   = r_age[i];
        end
        n_occ          = r_occ;
        n_rsp.hit      = found_any;
        n_rsp.read_value = '0;

        if (found_any) begin
            // hit: move entry to the front, younger entries age by one
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_valid[i] && (IDX_W'(i) != found_idx) && (r_age[i] < r_age[found_idx])) begin
                    n_age[i] = r_age[i] + AGE_W'(1);
                end
            end
            n_age[found_idx] = '0;
            if (r_req.operation == OP_PUT) begin
                n_value[found_idx] = r_req.put_value;
            end else begin
                n_rsp.read_value = r_value[found_idx];
            end
        end else if (r_req.operation == OP_PUT) begin
            // put miss: age survivors, insert new pair as most recent
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_valid[i] && !(evict && (IDX_W'(i) == slot))) begin
                    n_age[i] = r_age[i] + AGE_W'(1);
                end
            end
            n_valid[slot] = 1'b1;
            n_key[slot]   = r_req.key;
            n_value[slot] = r_req.put_value;
            n_age[slot]   = '0;
            if (!evict) begin
                n_occ = r_occ + OCC_W'(1);
            end
        end else begin
            n_rsp.read_value = MISS_VALUE;
        end
    end

    // table control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_occ <= '0;
        end else if (fire) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= n_valid[i];
            end
            r_occ <= n_occ;
        end
    end

    // table payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_key[i]   <= n_key[i];
                r_value[i] <= n_value[i];
                r_age[i]   <= n_age[i];
            end
        end
    end

endmodule

// ===== rtl/lkvc_checker.sv =====
`include "assert_macros.svh"

module lkvc_checker import lkvc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             o_req_stall,
    input  t_req             i_req,
    input  logic             o_rsp_valid,
    input  logic             i_rsp_stall,
    input  t_rsp             o_rsp
);

    // a stalled response holds
    `LKVC_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, o_rsp_valid && i_rsp_stall,
        o_rsp_valid && $stable(o_rsp))

    // a stalled request holds
    `LKVC_ASSERT_NEXT(a_req_hold, i_clk, i_rst_n, i_req_valid && o_req_stall,
        i_req_valid && $stable(i_req))

    // requests only back up when the response side is stalled
    `LKVC_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_req_stall,
        o_rsp_valid && i_rsp_stall)

    // a miss reports either the miss marker (get) or zero (put)
    `LKVC_ASSERT_NOW(a_miss_value, i_clk, i_rst_n, o_rsp_valid && !o_rsp.hit,
        (o_rsp.read_value == MISS_VALUE) || (o_rsp.read_value == 32'sd0))

    // no response right after reset, since the pipeline is empty
    `LKVC_ASSERT_NOW(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n),
        !o_rsp_valid)

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (.*);

// ===== dv/lru_key_value_cache_top_test.sv =====
// shadow copy of the cache: predicts each response and checks the block's output
class lru_cache_shadow;
    bit                             slot_valid[lkvc_pkg::ENTRIES];
    logic [31:0]                    slot_key[lkvc_pkg::ENTRIES];
    logic [31:0]                    slot_value[lkvc_pkg::ENTRIES];
    int unsigned                    slot_age[lkvc_pkg::ENTRIES];
    int unsigned                    occupancy;
    logic [lkvc_pkg::CAP_W-1:0]     capacity;
    lkvc_pkg::t_rsp                 owed_responses[$];
    int unsigned                    mismatches;
    int unsigned                    responses_seen;

    function new();
        foreach (slot_valid[i]) slot_valid[i] = 1'b0;
        occupancy      = 0;
        capacity       = lkvc_pkg::CAP_RESET;
        mismatches     = 0;
        responses_seen = 0;
    endfunction

    function void set_capacity(logic [lkvc_pkg::CAP_W-1:0] value);
        capacity = value;
    endfunction

    // zero acts as one, anything above the table size saturates
    function int unsigned usable_capacity();
        int unsigned c;
        c = capacity;
        if (c == 0) c = 1;
        if (c > lkvc_pkg::ENTRIES) c = lkvc_pkg::ENTRIES;
        return c;
    endfunction

    // move a slot to the front, entries younger than it age by one
    function void make_newest(int idx);
        int unsigned a;
        a = slot_age[idx];
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
            if (slot_valid[i] && i != idx && slot_age[i] < a) slot_age[i]++;
        end
        slot_age[idx] = 0;
    endfunction

    // apply one accepted request to the shadow state and queue its response
    function void note_request(lkvc_pkg::t_req req);
        int             hit_at;
        int             slot;
        lkvc_pkg::t_rsp rsp;
        hit_at = -1;
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
            if (slot_valid[i] && slot_key[i] == req.key) begin
                hit_at = i;
                break;
            end
        end

        if (req.operation == lkvc_pkg::OP_GET) begin
            if (hit_at >= 0) begin
                make_newest(hit_at);
                rsp.hit        = 1'b1;
                rsp.read_value = slot_value[hit_at];
            end else begin
                rsp.hit        = 1'b0;
                rsp.read_value = lkvc_pkg::MISS_VALUE;
            end
        end else begin
            rsp.read_value = '0;
            if (hit_at >= 0) begin
                slot_value[hit_at] = req.put_value;
                make_newest(hit_at);
                rsp.hit = 1'b1;
            end else begin
                rsp.hit = 1'b0;
                slot    = -1;
                // lowest free slot while below capacity
                if (occupancy < usable_capacity()) begin
                    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
                        if (!slot_valid[i]) begin
                            slot = i;
                            break;
                        end
                    end
                end
                // otherwise evict the single oldest valid entry
                if (slot < 0) begin
                    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
                        if (slot_valid[i] && (slot < 0 || slot_age[i] > slot_age[slot]))
                            slot = i;
                    end
                    if (slot < 0) slot = 0;
                    if (slot_valid[slot]) begin
                        slot_valid[slot] = 1'b0;
                        if (occupancy > 0) occupancy--;
                    end
                end
                for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
                    if (slot_valid[i]) slot_age[i]++;
                end
                slot_valid[slot] = 1'b1;
                slot_key[slot]   = req.key;
                slot_value[slot] = req.put_value;
                slot_age[slot]   = 0;
                occupancy++;
            end
        end
        owed_responses.push_back(rsp);
    endfunction

    task report_mismatch(string what);
        $display("mismatch on response %0d: %s", responses_seen, what);
        mismatches++;
    endtask

    // compare one accepted response with the oldest owed one
    task check_response(lkvc_pkg::t_rsp got);
        lkvc_pkg::t_rsp want;
        responses_seen++;
        if (owed_responses.size() == 0) begin
            report_mismatch("response arrived with no request outstanding");
        end else begin
            want = owed_responses.pop_front();
            if (got.hit !== want.hit)
                report_mismatch($sformatf("hit %b, expected %b", got.hit, want.hit));
            if (got.read_value !== want.read_value)
                report_mismatch($sformatf("read_value %h, expected %h",
                                          got.read_value, want.read_value));
        end
    endtask
endclass

module lru_key_value_cache_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lkvc_pkg::*;

    localparam int unsigned HOLD_CYCLES     = 80;
    localparam int unsigned DRAIN_CYCLES    = 6;
    localparam int unsigned ITEMS_PER_PHASE = 150;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [CAP_W-1:0] i_cfg_wr_data;
    logic             i_req_valid;
    logic             o_req_stall;
    t_req             i_req;
    logic             o_rsp_valid;
    logic             i_rsp_stall;
    t_rsp             o_rsp;

    lru_cache_shadow  shadow = new();
    logic [31:0]      key_pool[$];
    bit               hold_asked = 1'b0;

    lru_key_value_cache_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req_valid   (i_req_valid),
        .o_req_stall   (o_req_stall),
        .i_req         (i_req),
        .o_rsp_valid   (o_rsp_valid),
        .i_rsp_stall   (i_rsp_stall),
        .o_rsp         (o_rsp)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("lru_key_value_cache_top test failed");
        $finish;
    end

    function automatic logic [31:0] extreme_word();
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // keys for one phase: a few more than fit, some of them extremes
    function automatic void build_key_pool(int unsigned n);
        key_pool.delete();
        repeat (n) key_pool.push_back(($urandom_range(0, 3) == 0) ? extreme_word() : $urandom);
    endfunction

    function automatic t_req make_request(t_op op, logic [31:0] k, logic [31:0] v);
        t_req r;
        r.operation = op;
        r.key       = k;
        r.put_value = v;
        return r;
    endfunction

    // mostly pool keys so that hits and evictions both happen, some fully random
    function automatic t_req random_request();
        logic [31:0] k;
        logic [31:0] v;
        if (key_pool.size() == 0 || $urandom_range(0, 9) == 0) k = $urandom;
        else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        v = ($urandom_range(0, 9) == 0) ? extreme_word() : $urandom;
        return make_request(t_op'($urandom_range(0, 1)), k, v);
    endfunction

    // offer one request and hold it until accepted
    task automatic drive_request(t_req req);
        @(negedge i_clk);
        i_req_valid <= 1'b1;
        i_req       <= req;
        do @(posedge i_clk); while (o_req_stall);
        shadow.note_request(req);
    endtask

    task automatic idle_request(int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_req_valid <= 1'b0;
            i_req       <= random_request();
        end
    endtask

    // stop offering, wait for every owed response, then wait out the DRAIN_CYCLES drain
    task automatic wait_drained();
        @(negedge i_clk);
        i_req_valid <= 1'b0;
        while (shadow.owed_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        shadow.set_capacity(value);
    endtask

    // bursts of requests with random gaps
    task automatic run_random_phase(int unsigned count, bit ask_hold);
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst && sent < count; j++) begin
                drive_request(random_request());
                sent++;
                if (ask_hold && sent == 10) hold_asked = 1'b1;
            end
            if ($urandom_range(0, 2) != 0) idle_request($urandom_range(1, 6));
        end
    endtask

    // main sequence
    initial begin
        t_req             directed[$];
        logic [CAP_W-1:0] phase_caps[$];

        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_req_valid   = 1'b0;
        i_req         = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, hits, misses, overwrite, a stored value equal to the miss value
        directed = '{
            make_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF),
            make_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000),
            make_request(OP_GET, 32'h8000_0000, 32'h0000_0000),
            make_request(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF),
            make_request(OP_PUT, 32'h8000_0000, 32'h0000_0000),
            make_request(OP_GET, 32'h8000_0000, 32'h1234_5678),
            make_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
            make_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000),
            make_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000),
            make_request(OP_PUT, 32'h0000_0000, 32'h5A5A_5A5A)
        };
        foreach (directed[i]) drive_request(directed[i]);

        // capacity zero below the occupancy: each put miss evicts just one entry
        wait_drained();
        write_capacity(5'd0);
        directed = '{
            make_request(OP_PUT, 32'h1234_5678, 32'hA5A5_A5A5),
            make_request(OP_GET, 32'h8000_0000, 32'h0000_0000),
            make_request(OP_GET, 32'h0000_0000, 32'h0000_0000),
            make_request(OP_PUT, 32'h0F0F_0F0F, 32'hF0F0_F0F0),
            make_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000),
            make_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000),
            make_request(OP_PUT, 32'h0000_0000, 32'h0000_0001),
            make_request(OP_GET, 32'h1234_5678, 32'h0000_0000)
        };
        foreach (directed[i]) drive_request(directed[i]);

        // random phases over several capacities
        phase_caps = '{5'd1, 5'd16, 5'd31, 5'd2, 5'd0, 5'd7,
                       CAP_W'($urandom_range(0, 31)), CAP_W'($urandom_range(0, 31)), 5'd16};
        foreach (phase_caps[p]) begin
            wait_drained();
            write_capacity(phase_caps[p]);
            build_key_pool(shadow.usable_capacity() + $urandom_range(1, 6));
            run_random_phase(ITEMS_PER_PHASE, p == 2);
        end

        wait_drained();
        if (shadow.mismatches == 0) begin
            $display("lru_key_value_cache_top test passed");
        end else begin
            $display("lru_key_value_cache_top test failed");
        end
        $finish;
    end

    // response stall: stretches of differing patterns, one long hold-off on request
    initial begin
        int unsigned mode;
        int unsigned stretch;
        int unsigned tick;
        i_rsp_stall = 1'b0;
        tick        = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(5, 60);
            repeat (stretch) begin
                @(negedge i_clk);
                tick++;
                if (hold_asked) begin
                    hold_asked = 1'b0;
                    i_rsp_stall <= 1'b1;
                    repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                end else begin
                    case (mode)
                        0:       i_rsp_stall <= 1'b0;
                        1:       i_rsp_stall <= ($urandom_range(0, 3) == 0);
                        2:       i_rsp_stall <= ($urandom_range(0, 3) != 0);
                        default: i_rsp_stall <= (tick % 3 == 0);
                    endcase
                end
            end
        end
    end

    // response monitor
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_rsp_valid === 1'b1 && i_rsp_stall === 1'b0)
                shadow.check_response(o_rsp);
        end
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/lkvc_pkg.sv
rtl/lru_key_value_cache_top.sv
rtl/lkvc_checker.sv
dv/lru_key_value_cache_top_test.sv
